// ----- src/sha256_pkg.sv -----
// Package for the SHA-256 digest block: payload types, round constants, helpers.
package sha256_pkg;

  localparam int WordWidth   = 32;
  localparam int HashWords   = 8;
  localparam int WindowWords = 16;
  localparam int Rounds      = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] init_word(input logic [2:0] i);
    init_word = InitHash[(3'd7 - i) * 32 +: 32];
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
        6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
        6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
        6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
        6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
        6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
        6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
        6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
        6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
        6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
        6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
        6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
        6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
        6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
        6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
        6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
        6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
        6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
        6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
        6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
        6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
        6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
        6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      round_k = k;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- src/sha256_message_digest.sv -----
// Top level of the streaming SHA-256 digest block.
// One byte per word on the input. A byte that does not complete a block is
// written into the window; the 64th byte of a block then starts the 64 rounds
// in the shared round unit and the add into the hash. An end mark appends padding
// one byte at a time (9 to 72 bytes, one or two compressions), then shows the 8
// digest words, one per accepted output word. The input is not ready during this work.
module sha256_message_digest (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sha256_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sha256_pkg::out_word_t out_data
);
  import sha256_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SAbs  = 3'd1;
  localparam logic [2:0] SRnd  = 3'd2;
  localparam logic [2:0] SAdd  = 3'd3;
  localparam logic [2:0] SPad  = 3'd4;
  localparam logic [2:0] SOut  = 3'd5;

  logic [2:0]   state;
  logic [255:0] hash, vars, vars_rnd;
  logic [511:0] win;
  logic [5:0]   pos, rnd;
  logic [63:0]  bit_len;
  logic [7:0]   cur_byte;
  logic         pending_end, padding, pad_first;
  logic         len_phase, len_done;
  logic [2:0]   oidx;
  logic [31:0]  w_rnd;
  logic [31:0]  word_new;
  logic [7:0]   pad_byte;

  sha256_round u_round (
    .vars(vars), .win(win), .rnd(rnd), .vars_next(vars_rnd), .w_next(w_rnd)
  );

  assign in_ready  = (state == SIdle);
  assign out_valid = (state == SOut);
  assign out_data.digest_word = hash[(3'd7 - oidx) * 32 +: 32];
  assign out_data.word_index  = oidx;
  assign out_data.last_word   = (oidx == 3'd7);

  // padding byte for the current slot; length bytes only in the block that carries them
  always_comb begin
    if (pad_first) pad_byte = 8'h80;
    else if (len_phase && (pos inside {[6'd56:6'd63]})) pad_byte = bit_len[(6'd63 - pos) * 8 +: 8];
    else pad_byte = 8'h00;
  end

  // byte merge into window word pos/4 (bytes are written by index)
  always_comb begin
    word_new = (pos[1:0] == 2'd0) ? 32'h0 : win[(4'd15 - pos[5:2]) * 32 +: 32];
    word_new[(2'd3 - pos[1:0]) * 8 +: 8] = cur_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle; hash <= InitHash; vars <= '0;
      pos <= '0; bit_len <= '0; pending_end <= 1'b0;
      pad_first <= 1'b0; padding <= 1'b0; oidx <= '0; rnd <= '0;
      len_phase <= 1'b0; len_done <= 1'b0;
    end else begin
      case (state)
        SIdle: if (in_valid) begin
          pending_end <= in_data.end_of_message;
          pad_first <= 1'b1;
          cur_byte <= in_data.data_byte;
          if (in_data.has_byte) begin
            bit_len <= bit_len + 64'd8;
            state <= SAbs;
          end else if (in_data.end_of_message) begin
            state <= SPad;
          end
        end
        SPad: begin
          cur_byte <= pad_byte;
          // 0x80 before slot 56 leaves room for the length in this block
          if (pad_first) len_phase <= (pos < 6'd56);
          pad_first <= 1'b0;
          padding <= 1'b1;
          state <= SAbs;
        end
        SAbs: begin
          win[(4'd15 - pos[5:2]) * 32 +: 32] <= word_new;
          pos <= pos + 6'd1;
          // end of a padding block: length written, or move it to the next block
          if (padding && pos == 6'd63) begin
            if (len_phase) len_done <= 1'b1;
            else len_phase <= 1'b1;
          end
          if (pos == 6'd63) begin
            vars <= hash; rnd <= '0; state <= SRnd;
          end else if (padding || pending_end) begin
            state <= SPad;
          end else state <= SIdle;
        end
        SRnd: begin
          vars <= vars_rnd;
          win <= {win[479:0], w_rnd};
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= SAdd;
        end
        SAdd: begin
          for (int i = 0; i < 8; i++) hash[i*32 +: 32] <= hash[i*32 +: 32] + vars[i*32 +: 32];
          // a block that ends the length field finishes the message
          if (len_done) state <= SOut;
          else if (padding || pending_end) state <= SPad;
          else state <= SIdle;
        end
        SOut: if (out_ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            hash <= InitHash; bit_len <= '0; pending_end <= 1'b0;
            padding <= 1'b0; len_phase <= 1'b0; len_done <= 1'b0;
            state <= SIdle;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule

// ----- src/sha256_round.sv -----
// One SHA-256 round and schedule step, reused for every round of a block.
module sha256_round (
  input  logic [255:0] vars,
  input  logic [511:0] win,
  input  logic [5:0]   rnd,
  output logic [255:0] vars_next,
  output logic [31:0]  w_next
);
  import sha256_pkg::*;

  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] w0, w1, w9, w14, g0, g1, wr, t1, t2, s0, s1, ch, mj;

  // window is a shift line: word 0 in the top 32 bits
  assign w0  = win[511 -: 32];
  assign w1  = win[479 -: 32];
  assign w9  = win[223 -: 32];
  assign w14 = win[63 -: 32];
  assign {a, b, c, d, e, f, g, h} = vars;

  always_comb begin
    g0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    g1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    wr = (rnd < 6'd16) ? w0 : (w0 + g0 + w9 + g1);
    s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch = (e & f) ^ (~e & g);
    t1 = h + s1 + ch + round_k(rnd) + wr;
    s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    mj = (a & b) ^ (b & c) ^ (c & a);
    t2 = s0 + mj;
    vars_next = {t1 + t2, a, b, c, d + t1, e, f, g};
    w_next = wr;
  end
endmodule

// ----- src/sha256_checker.sv -----
// Port-level checks for the SHA-256 digest block, bound to the top level.
module sha256_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sha256_pkg::out_word_t out_data
);
  import sha256_pkg::*;

  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while digest shown");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digest word changed while stalled");
  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_word |=> out_valid)
    else $error("digest sequence broken");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last flag mismatch");
endmodule

bind sha256_message_digest sha256_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
